// ===== rtl/mfhp_pkg.sv =====
// ----------------------------------------------------------------------------
// mfhp_pkg
// Shared constants, result codes and lookup tables for the MPEG audio frame
// header parser.
// ----------------------------------------------------------------------------
`default_nettype none

package mfhp_pkg;

  // Frame length numerator: coefficient (<= 144000) times kbps (<= 448)
  localparam int DIVIDEND_W = 26;
  // Sample rate in Hz
  localparam int DIVISOR_W  = 16;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_SYNC = 2'd1;
  localparam logic [1:0] ST_BAD_HDR = 2'd2;

  localparam logic [1:0] VER_RESERVED = 2'd1;
  localparam logic [1:0] VER_MPEG1    = 2'd3;
  localparam logic [1:0] MODE_MONO    = 2'd3;

  localparam logic [7:0] SYNC_BYTE = 8'hFF;

  // Frame length coefficients: 12000 for layer 1, spf*125 otherwise
  localparam logic [17:0] COEF_L1      = 18'd12000;
  localparam logic [17:0] COEF_SPF1152 = 18'd144000;
  localparam logic [17:0] COEF_SPF576  = 18'd72000;

  // Bitrate in kbit/s; vidx 0 = MPEG1, 1 = MPEG2/2.5; lidx 0..2 = layer 1..3
  function automatic logic [8:0] kbps_lookup(input logic       vidx,
                                             input logic [1:0] lidx,
                                             input logic [3:0] bri);
    logic [8:0] v;
    v = 9'd0;
    if (!vidx) begin
      unique case (lidx)
        2'd0: begin
          unique case (bri)
            4'd1: v = 9'd32;   4'd2: v = 9'd64;   4'd3: v = 9'd96;
            4'd4: v = 9'd128;  4'd5: v = 9'd160;  4'd6: v = 9'd192;
            4'd7: v = 9'd224;  4'd8: v = 9'd256;  4'd9: v = 9'd288;
            4'd10: v = 9'd320; 4'd11: v = 9'd352; 4'd12: v = 9'd384;
            4'd13: v = 9'd416; 4'd14: v = 9'd448;
            default: v = 9'd0;
          endcase
        end
        2'd1: begin
          unique case (bri)
            4'd1: v = 9'd32;   4'd2: v = 9'd48;   4'd3: v = 9'd56;
            4'd4: v = 9'd64;   4'd5: v = 9'd80;   4'd6: v = 9'd96;
            4'd7: v = 9'd112;  4'd8: v = 9'd128;  4'd9: v = 9'd160;
            4'd10: v = 9'd192; 4'd11: v = 9'd224; 4'd12: v = 9'd256;
            4'd13: v = 9'd320; 4'd14: v = 9'd384;
            default: v = 9'd0;
          endcase
        end
        default: begin
          unique case (bri)
            4'd1: v = 9'd32;   4'd2: v = 9'd40;   4'd3: v = 9'd48;
            4'd4: v = 9'd56;   4'd5: v = 9'd64;   4'd6: v = 9'd80;
            4'd7: v = 9'd96;   4'd8: v = 9'd112;  4'd9: v = 9'd128;
            4'd10: v = 9'd160; 4'd11: v = 9'd192; 4'd12: v = 9'd224;
            4'd13: v = 9'd256; 4'd14: v = 9'd320;
            default: v = 9'd0;
          endcase
        end
      endcase
    end else if (lidx == 2'd0) begin
      unique case (bri)
        4'd1: v = 9'd32;   4'd2: v = 9'd48;   4'd3: v = 9'd56;
        4'd4: v = 9'd64;   4'd5: v = 9'd80;   4'd6: v = 9'd96;
        4'd7: v = 9'd112;  4'd8: v = 9'd128;  4'd9: v = 9'd144;
        4'd10: v = 9'd160; 4'd11: v = 9'd176; 4'd12: v = 9'd192;
        4'd13: v = 9'd224; 4'd14: v = 9'd256;
        default: v = 9'd0;
      endcase
    end else begin
      unique case (bri)
        4'd1: v = 9'd8;    4'd2: v = 9'd16;   4'd3: v = 9'd24;
        4'd4: v = 9'd32;   4'd5: v = 9'd40;   4'd6: v = 9'd48;
        4'd7: v = 9'd56;   4'd8: v = 9'd64;   4'd9: v = 9'd80;
        4'd10: v = 9'd96;  4'd11: v = 9'd112; 4'd12: v = 9'd128;
        4'd13: v = 9'd144; 4'd14: v = 9'd160;
        default: v = 9'd0;
      endcase
    end
    return v;
  endfunction

  // Sample rate in Hz; zero for reserved codes
  function automatic logic [15:0] rate_lookup(input logic [1:0] ver,
                                              input logic [1:0] sri);
    logic [15:0] v;
    v = 16'd0;
    unique case (ver)
      2'd0: begin
        unique case (sri)
          2'd0: v = 16'd11025; 2'd1: v = 16'd12000; 2'd2: v = 16'd8000;
          default: v = 16'd0;
        endcase
      end
      2'd2: begin
        unique case (sri)
          2'd0: v = 16'd22050; 2'd1: v = 16'd24000; 2'd2: v = 16'd16000;
          default: v = 16'd0;
        endcase
      end
      2'd3: begin
        unique case (sri)
          2'd0: v = 16'd44100; 2'd1: v = 16'd48000; 2'd2: v = 16'd32000;
          default: v = 16'd0;
        endcase
      end
      default: v = 16'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/mfhp_div.sv =====
// ----------------------------------------------------------------------------
// mfhp_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mfhp_div #(
  parameter int NUM_W = mfhp_pkg::DIVIDEND_W,
  parameter int DEN_W = mfhp_pkg::DIVISOR_W
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic [NUM_W-1:0]      quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [NUM_W-1:0] quot_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;

  logic [DEN_W:0]   shifted;
  logic [DEN_W+1:0] diff;
  logic             fits;
  logic [DEN_W-1:0] rem_nxt;
  logic [NUM_W-1:0] quot_nxt;

  // Remainder stays below the divisor, so the DEN_W low bits suffice
  always_comb begin
    shifted  = {rem_r, quot_r[NUM_W-1]};
    diff     = {1'b0, shifted} - {2'b00, den_r};
    fits     = !diff[DEN_W+1];
    rem_nxt  = fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
    quot_nxt = {quot_r[NUM_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot_r <= num;
      rem_r  <= '0;
      den_r  <= den;
    end else if (busy_r) begin
      quot_r <= quot_nxt;
      rem_r  <= rem_nxt;
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

`default_nettype wire

// ===== rtl/mp3_frame_header_parser.sv =====
// ----------------------------------------------------------------------------
// mp3_frame_header_parser
// Scans a chunk's bytes for an MPEG audio frame sync, decodes the header and
// reports one result per chunk, with frame length from a divider.
// ----------------------------------------------------------------------------
//
//   channel  handshake            payload
//   in_      in_valid/in_ready    data_byte, first_of_chunk, last_of_chunk
//   out_     out_valid/out_ready  status and eleven decoded header fields
//
// Bytes are taken one per cycle while scanning. The byte that completes a
// header holds in_ready low through a decode state, the divider (26 quotient
// bits, then the done flag) and an output load; an invalid header skips the
// divider. The output load also waits for a free output register. Scanning
// carries on past a waiting result unless a chunk-end byte would need the
// still-occupied register. Synchronous active-low reset.
// ----------------------------------------------------------------------------
`default_nettype none

module mp3_frame_header_parser (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_first_of_chunk,
  input  wire logic        in_last_of_chunk,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status,
  output logic [1:0]       out_mpeg_version,
  output logic [1:0]       out_layer_number,
  output logic [8:0]       out_bitrate_kbps,
  output logic [15:0]      out_sample_rate_hz,
  output logic [1:0]       out_channel_mode,
  output logic [1:0]       out_channel_count,
  output logic             out_padding_bit,
  output logic [11:0]      out_frame_length,
  output logic [15:0]      out_mp3_bytes_per_sec,
  output logic [17:0]      out_pcm_bytes_per_sec,
  output logic [2:0]       out_pcm_block_align
);

  localparam int NUM_W = mfhp_pkg::DIVIDEND_W;
  localparam int DEN_W = mfhp_pkg::DIVISOR_W;

  typedef enum logic [1:0] {S_SCAN, S_DECODE, S_DIV, S_EMIT} state_t;

  state_t      state_r;
  logic [1:0]  phase_r;
  logic        fin_r;
  logic [7:0]  b2_r;
  logic [7:0]  b3_r;
  logic [1:0]  mode_r;

  // decoded header held across the division
  logic        bad_r;
  logic [1:0]  ver_r;
  logic [1:0]  lidx_r;
  logic [8:0]  kbps_r;
  logic [15:0] rate_r;
  logic        pad_r;

  logic        out_valid_r;
  logic [1:0]  out_status_r;
  logic [1:0]  out_ver_r;
  logic [1:0]  out_layer_r;
  logic [8:0]  out_kbps_r;
  logic [15:0] out_rate_r;
  logic [1:0]  out_mode_r;
  logic [1:0]  out_chans_r;
  logic        out_pad_r;
  logic [11:0] out_flen_r;
  logic [15:0] out_mp3_r;
  logic [17:0] out_pcm_r;
  logic [2:0]  out_align_r;

  logic        accept;
  logic [1:0]  eff_phase;
  logic        eff_fin;
  logic        emit_no_sync;
  logic        out_free;

  logic [1:0]  d_ver;
  logic [1:0]  d_lay;
  logic [3:0]  d_bri;
  logic [1:0]  d_sri;
  logic        d_vidx;
  logic [1:0]  d_lidx;
  logic        d_bad;
  logic [8:0]  d_kbps;
  logic [15:0] d_rate;
  logic [17:0] d_coef;
  logic [26:0] d_prod;

  logic        div_start;
  logic        div_done;
  logic [NUM_W-1:0] div_quot;

  logic        mono;
  logic [11:0] flen;
  logic [15:0] mp3_rate;
  logic [17:0] pcm_rate;

  // ---- byte scan ----
  always_comb begin
    eff_phase    = in_first_of_chunk ? 2'd0 : phase_r;
    eff_fin      = in_first_of_chunk ? 1'b0 : fin_r;
    out_free     = !out_valid_r || out_ready;
    emit_no_sync = !eff_fin && (eff_phase != 2'd3) && in_last_of_chunk;
    in_ready     = (state_r == S_SCAN) && (out_free || !emit_no_sync);
    accept       = in_valid && in_ready;
  end

  // ---- header decode ----
  always_comb begin
    d_ver  = b2_r[4:3];
    d_lay  = b2_r[2:1];
    d_bri  = b3_r[7:4];
    d_sri  = b3_r[3:2];
    d_vidx = (d_ver != mfhp_pkg::VER_MPEG1);
    d_lidx = 2'd3 - d_lay;
    d_bad  = (d_ver == mfhp_pkg::VER_RESERVED) || (d_lay == 2'd0) ||
             (d_bri == 4'd0) || (d_bri == 4'd15) || (d_sri == 2'd3);
    d_kbps = mfhp_pkg::kbps_lookup(d_vidx, d_lidx, d_bri);
    d_rate = mfhp_pkg::rate_lookup(d_ver, d_sri);
    priority if (d_lidx == 2'd0)
      d_coef = mfhp_pkg::COEF_L1;
    else if (d_lidx == 2'd2 && d_vidx)
      d_coef = mfhp_pkg::COEF_SPF576;
    else
      d_coef = mfhp_pkg::COEF_SPF1152;
    d_prod    = d_coef * {9'd0, d_kbps};
    div_start = (state_r == S_DECODE) && !d_bad;
  end

  mfhp_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (d_prod[NUM_W-1:0]),
    .den   (d_rate),
    .done  (div_done),
    .quot  (div_quot)
  );

  // ---- result fields from the held header ----
  always_comb begin
    mono     = (mode_r == mfhp_pkg::MODE_MONO);
    mp3_rate = {7'd0, kbps_r} * 16'd125;
    pcm_rate = mono ? {1'b0, rate_r, 1'b0} : {rate_r, 2'b00};
    if (lidx_r == 2'd0)
      flen = {div_quot[9:0] + {9'd0, pad_r}, 2'b00};
    else
      flen = div_quot[11:0] + {11'd0, pad_r};
  end

  // ---- sequencer, scan state and output register ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SCAN;
      phase_r     <= 2'd0;
      fin_r       <= 1'b0;
      b2_r        <= 8'd0;
      b3_r        <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready)
        out_valid_r <= 1'b0;

      unique case (state_r)
        S_SCAN: begin
          if (accept) begin
            phase_r <= eff_phase;
            fin_r   <= eff_fin;
            if (!eff_fin) begin
              unique case (eff_phase)
                2'd0: begin
                  if (in_data_byte == mfhp_pkg::SYNC_BYTE)
                    phase_r <= 2'd1;
                end
                2'd1: begin
                  if (in_data_byte[7:5] == 3'b111) begin
                    b2_r    <= in_data_byte;
                    phase_r <= 2'd2;
                  end else begin
                    phase_r <= 2'd0;
                  end
                end
                2'd2: begin
                  b3_r    <= in_data_byte;
                  phase_r <= 2'd3;
                end
                default: begin
                  mode_r  <= in_data_byte[7:6];
                  phase_r <= 2'd0;
                  fin_r   <= 1'b1;
                  state_r <= S_DECODE;
                end
              endcase
              if (emit_no_sync) begin
                phase_r      <= 2'd0;
                fin_r        <= 1'b1;
                out_valid_r  <= 1'b1;
                out_status_r <= mfhp_pkg::ST_NO_SYNC;
                out_ver_r    <= '0;
                out_layer_r  <= '0;
                out_kbps_r   <= '0;
                out_rate_r   <= '0;
                out_mode_r   <= '0;
                out_chans_r  <= '0;
                out_pad_r    <= '0;
                out_flen_r   <= '0;
                out_mp3_r    <= '0;
                out_pcm_r    <= '0;
                out_align_r  <= '0;
              end
            end
          end
        end
        S_DECODE: begin
          bad_r   <= d_bad;
          ver_r   <= d_ver;
          lidx_r  <= d_lidx;
          kbps_r  <= d_kbps;
          rate_r  <= d_rate;
          pad_r   <= b3_r[1];
          state_r <= d_bad ? S_EMIT : S_DIV;
        end
        S_DIV: begin
          if (div_done)
            state_r <= S_EMIT;
        end
        default: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            state_r     <= S_SCAN;
            if (bad_r) begin
              out_status_r <= mfhp_pkg::ST_BAD_HDR;
              out_ver_r    <= '0;
              out_layer_r  <= '0;
              out_kbps_r   <= '0;
              out_rate_r   <= '0;
              out_mode_r   <= '0;
              out_chans_r  <= '0;
              out_pad_r    <= '0;
              out_flen_r   <= '0;
              out_mp3_r    <= '0;
              out_pcm_r    <= '0;
              out_align_r  <= '0;
            end else begin
              out_status_r <= mfhp_pkg::ST_OK;
              out_ver_r    <= ver_r;
              out_layer_r  <= lidx_r + 2'd1;
              out_kbps_r   <= kbps_r;
              out_rate_r   <= rate_r;
              out_mode_r   <= mode_r;
              out_chans_r  <= mono ? 2'd1 : 2'd2;
              out_pad_r    <= pad_r;
              out_flen_r   <= flen;
              out_mp3_r    <= mp3_rate;
              out_pcm_r    <= pcm_rate;
              out_align_r  <= mono ? 3'd2 : 3'd4;
            end
          end
        end
      endcase
    end
  end

  assign out_valid             = out_valid_r;
  assign out_status            = out_status_r;
  assign out_mpeg_version      = out_ver_r;
  assign out_layer_number      = out_layer_r;
  assign out_bitrate_kbps      = out_kbps_r;
  assign out_sample_rate_hz    = out_rate_r;
  assign out_channel_mode      = out_mode_r;
  assign out_channel_count     = out_chans_r;
  assign out_padding_bit       = out_pad_r;
  assign out_frame_length      = out_flen_r;
  assign out_mp3_bytes_per_sec = out_mp3_r;
  assign out_pcm_bytes_per_sec = out_pcm_r;
  assign out_pcm_block_align   = out_align_r;

`ifndef SYNTHESIS
  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV)
    else $error("divider finished outside the divide state");

  a_hdr_to_decode: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !in_first_of_chunk && !fin_r && phase_r == 2'd3 |=>
      state_r == S_DECODE)
    else $error("completed header did not start a decode");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != mfhp_pkg::ST_OK |->
      out_flen_r == 12'd0 && out_chans_r == 2'd0 && out_rate_r == 16'd0)
    else $error("error result carries non-zero fields");

  a_ok_sane: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r == mfhp_pkg::ST_OK |->
      out_layer_r != 2'd0 && out_rate_r != 16'd0 && out_flen_r != 12'd0)
    else $error("good header with empty fields");
`endif

endmodule

`default_nettype wire

// ===== test/mp3_header_checker.sv =====
// ----------------------------------------------------------------------------
// mp3_header_checker
// Watches both channels of the frame header parser. It tracks the byte
// scan of each chunk on its own, predicts the decoded header or error
// result and compares each result transfer, field by field, with the
// oldest prediction.
// ----------------------------------------------------------------------------
module mp3_header_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_first_of_chunk,
  input  logic        in_last_of_chunk,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  out_status,
  input  logic [1:0]  out_mpeg_version,
  input  logic [1:0]  out_layer_number,
  input  logic [8:0]  out_bitrate_kbps,
  input  logic [15:0] out_sample_rate_hz,
  input  logic [1:0]  out_channel_mode,
  input  logic [1:0]  out_channel_count,
  input  logic        out_padding_bit,
  input  logic [11:0] out_frame_length,
  input  logic [15:0] out_mp3_bytes_per_sec,
  input  logic [17:0] out_pcm_bytes_per_sec,
  input  logic [2:0]  out_pcm_block_align,
  output int          fail_count,
  output int          pending,
  output int          decoded_count,
  output int          no_sync_count,
  output int          rejected_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] SYNC_TAIL_MASK = 8'hE0;
  localparam logic [1:0] LAYER_RESERVED = 2'd0;
  localparam logic [3:0] BRI_FREE       = 4'd0;
  localparam logic [3:0] BRI_BAD        = 4'd15;
  localparam logic [1:0] SRI_RESERVED   = 2'd3;

  typedef enum logic [1:0] {HUNT, GOT_SYNC, GOT_B2, GOT_B3} scan_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  version;
    logic [1:0]  layer;
    logic [8:0]  kbps;
    logic [15:0] rate;
    logic [1:0]  mode;
    logic [1:0]  chans;
    logic        pad;
    logic [11:0] frame_len;
    logic [15:0] mp3_bps;
    logic [17:0] pcm_bps;
    logic [2:0]  align;
  } hdr_result_t;

  // index: vidx*48 + lidx*16 + bitrate index (vidx 0 = MPEG1, lidx 0 = layer 1)
  int unsigned kbps_by_code [96] = '{
    0, 32, 64, 96, 128, 160, 192, 224, 256, 288, 320, 352, 384, 416, 448, 0,
    0, 32, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 384, 0,
    0, 32, 40, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 0,
    0, 32, 48, 56, 64, 80, 96, 112, 128, 144, 160, 176, 192, 224, 256, 0,
    0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160, 0,
    0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160, 0
  };

  // index: version code*4 + rate index
  int unsigned hz_by_code [16] = '{
    11025, 12000, 8000, 0,
    0, 0, 0, 0,
    22050, 24000, 16000, 0,
    44100, 48000, 32000, 0
  };

  scan_t       scan;
  logic [7:0]  hdr_b2;
  logic [7:0]  hdr_b3;
  logic        chunk_done;
  hdr_result_t expected_hdrs [$];

  function automatic hdr_result_t decode_header(input logic [7:0] b2, input logic [7:0] b3,
                                                input logic [7:0] b4);
    hdr_result_t r;
    logic [1:0]  ver;
    logic [1:0]  lay;
    logic [3:0]  bri;
    logic [1:0]  sri;
    int unsigned vidx, lidx, kbps, rate, chans, flen, spf;
    r   = '0;
    ver = b2[4:3];
    lay = b2[2:1];
    bri = b3[7:4];
    sri = b3[3:2];
    if (ver == mfhp_pkg::VER_RESERVED || lay == LAYER_RESERVED || bri == BRI_FREE ||
        bri == BRI_BAD || sri == SRI_RESERVED) begin
      r.status = mfhp_pkg::ST_BAD_HDR;
      return r;
    end
    vidx = (ver == mfhp_pkg::VER_MPEG1) ? 0 : 1;
    lidx = 3 - lay;
    kbps = kbps_by_code[vidx * 48 + lidx * 16 + bri];
    rate = hz_by_code[ver * 4 + sri];
    if (rate == 0) begin
      r.status = mfhp_pkg::ST_BAD_HDR;
      return r;
    end
    chans = (b4[7:6] == mfhp_pkg::MODE_MONO) ? 1 : 2;
    if (lidx == 0) begin
      flen = (12000 * kbps / rate + b3[1]) * 4;
    end else begin
      // layer 3 of the low-rate versions carries half the samples per frame
      spf  = (lidx == 2 && vidx == 1) ? 576 : 1152;
      flen = spf * 125 * kbps / rate + b3[1];
    end
    r.status    = mfhp_pkg::ST_OK;
    r.version   = ver;
    r.layer     = 2'(lidx + 1);
    r.kbps      = 9'(kbps);
    r.rate      = 16'(rate);
    r.mode      = b4[7:6];
    r.chans     = 2'(chans);
    r.pad       = b3[1];
    r.frame_len = 12'(flen);
    r.mp3_bps   = 16'(kbps * 125);
    r.pcm_bps   = 18'(rate * chans * 2);
    r.align     = 3'(chans * 2);
    return r;
  endfunction

  task automatic track_byte(input logic [7:0] b, input logic first, input logic last);
    hdr_result_t err;
    bit          gave;
    gave = 1'b0;
    if (first) begin
      scan       = HUNT;
      chunk_done = 1'b0;
    end
    if (!chunk_done) begin
      case (scan)
        HUNT: begin
          if (b == mfhp_pkg::SYNC_BYTE) scan = GOT_SYNC;
        end
        GOT_SYNC: begin
          if ((b & SYNC_TAIL_MASK) == SYNC_TAIL_MASK) begin
            hdr_b2 = b;
            scan   = GOT_B2;
          end else begin
            scan = HUNT;
          end
        end
        GOT_B2: begin
          hdr_b3 = b;
          scan   = GOT_B3;
        end
        default: begin
          expected_hdrs.push_back(decode_header(hdr_b2, hdr_b3, b));
          scan       = HUNT;
          chunk_done = 1'b1;
          gave       = 1'b1;
        end
      endcase
      // a chunk that ends short of a full header reports no sync
      if (!gave && last) begin
        err        = '0;
        err.status = mfhp_pkg::ST_NO_SYNC;
        expected_hdrs.push_back(err);
        scan       = HUNT;
        chunk_done = 1'b1;
      end
    end
  endtask

  function automatic string fmt_hdr(input hdr_result_t r);
    return $sformatf({"st=%0d ver=%0d lay=%0d kbps=%0d hz=%0d mode=%0d ch=%0d pad=%0d ",
                      "len=%0d mp3Bps=%0d pcmBps=%0d align=%0d"},
                     r.status, r.version, r.layer, r.kbps, r.rate, r.mode, r.chans, r.pad,
                     r.frame_len, r.mp3_bps, r.pcm_bps, r.align);
  endfunction

  task automatic note_failure(input string msg);
    if (fail_count < 10) $display("[%0t] ERROR: %s", $realtime, msg);
    fail_count++;
  endtask

  always @(posedge clk) begin : watch
    hdr_result_t got;
    hdr_result_t want;
    if (!rst_n) begin
      scan           = HUNT;
      hdr_b2         = '0;
      hdr_b3         = '0;
      chunk_done     = 1'b0;
      expected_hdrs.delete();
      fail_count     = 0;
      decoded_count  = 0;
      no_sync_count  = 0;
      rejected_count = 0;
    end else begin
      if (in_valid && in_ready)
        track_byte(in_data_byte, in_first_of_chunk, in_last_of_chunk);
      if (out_valid && out_ready) begin
        got.status    = out_status;
        got.version   = out_mpeg_version;
        got.layer     = out_layer_number;
        got.kbps      = out_bitrate_kbps;
        got.rate      = out_sample_rate_hz;
        got.mode      = out_channel_mode;
        got.chans     = out_channel_count;
        got.pad       = out_padding_bit;
        got.frame_len = out_frame_length;
        got.mp3_bps   = out_mp3_bytes_per_sec;
        got.pcm_bps   = out_pcm_bytes_per_sec;
        got.align     = out_pcm_block_align;
        if (expected_hdrs.size() == 0) begin
          note_failure({"result with nothing outstanding: ", fmt_hdr(got)});
        end else begin
          want = expected_hdrs.pop_front();
          if (got !== want)
            note_failure({"result mismatch\n  expected ", fmt_hdr(want),
                          "\n  actual   ", fmt_hdr(got)});
        end
        case (got.status)
          mfhp_pkg::ST_OK:      decoded_count++;
          mfhp_pkg::ST_NO_SYNC: no_sync_count++;
          default:              rejected_count++;
        endcase
      end
    end
    pending = expected_hdrs.size();
  end

endmodule

// ===== test/mp3_frame_header_parser_tb.sv =====
// ----------------------------------------------------------------------------
// mp3_frame_header_parser_tb
// Feeds chunks of compressed audio bytes to the frame header parser: a short
// hand-written set of headers and cut-off chunks, then random chunks that
// mostly carry a sync and header among noise. Both channels stall at random;
// a separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module mp3_frame_header_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] VER_MPEG25  = 2'd0;
  localparam logic [1:0] VER_MPEG2   = 2'd2;
  localparam int         BYTE_TARGET = 450;
  localparam int         CYCLE_LIMIT = 200000;
  localparam int         DRAIN_CYCLES = 60;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = '0;
  logic        in_first_of_chunk = 1'b0;
  logic        in_last_of_chunk = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_status;
  logic [1:0]  out_mpeg_version;
  logic [1:0]  out_layer_number;
  logic [8:0]  out_bitrate_kbps;
  logic [15:0] out_sample_rate_hz;
  logic [1:0]  out_channel_mode;
  logic [1:0]  out_channel_count;
  logic        out_padding_bit;
  logic [11:0] out_frame_length;
  logic [15:0] out_mp3_bytes_per_sec;
  logic [17:0] out_pcm_bytes_per_sec;
  logic [2:0]  out_pcm_block_align;

  int          fail_count;
  int          pending;
  int          decoded_count;
  int          no_sync_count;
  int          rejected_count;
  int          bytes_sent = 0;
  int unsigned cycle_count = 0;
  bit          quiet = 1'b0;

  always #5 clk = ~clk;

  mp3_frame_header_parser DUT (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_data_byte          (in_data_byte),
    .in_first_of_chunk     (in_first_of_chunk),
    .in_last_of_chunk      (in_last_of_chunk),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_status            (out_status),
    .out_mpeg_version      (out_mpeg_version),
    .out_layer_number      (out_layer_number),
    .out_bitrate_kbps      (out_bitrate_kbps),
    .out_sample_rate_hz    (out_sample_rate_hz),
    .out_channel_mode      (out_channel_mode),
    .out_channel_count     (out_channel_count),
    .out_padding_bit       (out_padding_bit),
    .out_frame_length      (out_frame_length),
    .out_mp3_bytes_per_sec (out_mp3_bytes_per_sec),
    .out_pcm_bytes_per_sec (out_pcm_bytes_per_sec),
    .out_pcm_block_align   (out_pcm_block_align)
  );

  mp3_header_checker u_checker (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_data_byte          (in_data_byte),
    .in_first_of_chunk     (in_first_of_chunk),
    .in_last_of_chunk      (in_last_of_chunk),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_status            (out_status),
    .out_mpeg_version      (out_mpeg_version),
    .out_layer_number      (out_layer_number),
    .out_bitrate_kbps      (out_bitrate_kbps),
    .out_sample_rate_hz    (out_sample_rate_hz),
    .out_channel_mode      (out_channel_mode),
    .out_channel_count     (out_channel_count),
    .out_padding_bit       (out_padding_bit),
    .out_frame_length      (out_frame_length),
    .out_mp3_bytes_per_sec (out_mp3_bytes_per_sec),
    .out_pcm_bytes_per_sec (out_pcm_bytes_per_sec),
    .out_pcm_block_align   (out_pcm_block_align),
    .fail_count            (fail_count),
    .pending               (pending),
    .decoded_count         (decoded_count),
    .no_sync_count         (no_sync_count),
    .rejected_count        (rejected_count)
  );

  always @(negedge clk) begin
    out_ready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 38);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_byte(input logic [7:0] data, input bit first, input bit last);
    while (!quiet && $urandom_range(0, 99) < 38) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid          <= 1'b1;
    in_data_byte      <= data;
    in_first_of_chunk <= first;
    in_last_of_chunk  <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  task automatic send_chunk();
    logic [7:0] bytes [$];
    int         kind;
    int         cut;
    bit         marked;
    bit         ends;
    logic [1:0] ver;
    logic [1:0] lay;
    logic [3:0] bri;
    logic [1:0] sri;
    kind   = $urandom_range(0, 99);
    marked = ($urandom_range(0, 9) != 0);
    ends   = ($urandom_range(0, 19) != 0);
    // leading noise, sometimes a false sync
    repeat ($urandom_range(0, 3)) begin
      if ($urandom_range(0, 4) == 0) begin
        bytes.push_back(mfhp_pkg::SYNC_BYTE);
        bytes.push_back(8'($urandom_range(0, 8'hDF)));
      end else begin
        bytes.push_back(8'($urandom_range(0, 8'hFE)));
      end
    end
    if (kind < 70) begin
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 2))
          0:       ver = VER_MPEG25;
          1:       ver = VER_MPEG2;
          default: ver = mfhp_pkg::VER_MPEG1;
        endcase
        lay = 2'($urandom_range(1, 3));
        bri = 4'($urandom_range(1, 14));
        sri = 2'($urandom_range(0, 2));
      end else begin
        ver = 2'($urandom);
        lay = 2'($urandom);
        bri = 4'($urandom);
        sri = 2'($urandom);
      end
      bytes.push_back(mfhp_pkg::SYNC_BYTE);
      bytes.push_back({3'b111, ver, lay, 1'($urandom)});
      bytes.push_back({bri, sri, 2'($urandom)});
      bytes.push_back(8'($urandom));
      repeat ($urandom_range(0, 3)) bytes.push_back(8'($urandom));
    end else if (kind < 85) begin
      // header cut off by the chunk end
      cut = $urandom_range(1, 3);
      bytes.push_back(mfhp_pkg::SYNC_BYTE);
      if (cut >= 2) bytes.push_back({3'b111, 5'($urandom)});
      if (cut >= 3) bytes.push_back(8'($urandom));
    end else begin
      repeat ($urandom_range(1, 8)) bytes.push_back(8'($urandom));
    end
    foreach (bytes[i])
      send_byte(bytes[i], marked && i == 0, ends && i == bytes.size() - 1);
  endtask

  initial begin
    int chunk_idx;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // unmarked start after reset, then a byte past the result
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'hFB, 1'b0, 1'b0);
    send_byte(8'h90, 1'b0, 1'b0);
    send_byte(8'h64, 1'b0, 1'b0);
    send_byte(8'h11, 1'b0, 1'b1);
    // double 0xFF: the second one is the header byte (layer 1, 448k, mono)
    send_byte(8'hFF, 1'b1, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'hE4, 1'b0, 1'b0);
    send_byte(8'hC0, 1'b0, 1'b0);
    send_byte(8'hC3, 1'b0, 1'b1);
    // single-byte chunk, sync cut off
    send_byte(8'hFF, 1'b1, 1'b1);
    // false sync, then a header cut short
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'h1F, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'hE3, 1'b0, 1'b1);
    // longest frame: MPEG2.5 layer 2, 160k, 8 kHz, padded; last on final header byte
    send_byte(8'hFF, 1'b1, 1'b0);
    send_byte(8'hE5, 1'b0, 1'b0);
    send_byte(8'hEA, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b1);
    // reserved version code
    send_byte(8'hFF, 1'b1, 1'b0);
    send_byte(8'hEA, 1'b0, 1'b0);
    send_byte(8'h50, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b1);

    chunk_idx = 0;
    while (bytes_sent < BYTE_TARGET) begin
      if (chunk_idx == 12) wait_results_drained();
      quiet = (chunk_idx >= 25 && chunk_idx < 40);
      send_chunk();
      chunk_idx++;
    end
    quiet = 1'b0;

    wait_results_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Sent %0d bytes in %0d random chunks after the directed set", bytes_sent,
             chunk_idx);
    $display("Results: %0d headers decoded, %0d without sync, %0d rejected", decoded_count,
             no_sync_count, rejected_count);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
